### rtl/romu_pkg.sv
package romu_pkg;

    localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL1    = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL2    = 64'h94d049bb133111eb;
    localparam logic [63:0] ROMU_MUL    = 64'd15241094284759029579;

    localparam int MIX_SHIFT0 = 30;
    localparam int MIX_SHIFT1 = 27;
    localparam int MIX_SHIFT2 = 31;
    localparam int ROT_W      = 52;
    localparam int ROT_YW     = 19;

    // normalizer works on a 53-bit word, leading one ends at the top bit
    localparam int NORM_W     = 53;
    localparam int NORM_STEPS = 6;

    localparam logic [23:0]       F32_HALF = 24'h400000;
    localparam logic [NORM_W-1:0] F64_HALF = 53'h8000000000000;

    // exponent field for a value whose leading one sits at the top bit
    localparam logic [10:0] EXP_F32_S = 11'd128;
    localparam logic [10:0] EXP_F32_U = 11'd127;
    localparam logic [10:0] EXP_F64_S = 11'd1024;
    localparam logic [10:0] EXP_F64_U = 11'd1023;

    typedef enum logic [2:0] {
        FMT_RAW     = 3'd0,
        FMT_F32_S   = 3'd1,
        FMT_F64_S   = 3'd2,
        FMT_F32_U   = 3'd3,
        FMT_F64_U   = 3'd4,
        FMT_F32X2_S = 3'd5,
        FMT_F32X2_U = 3'd6
    } t_fmt;

    typedef enum logic {
        CMD_DRAW   = 1'b0,
        CMD_RESEED = 1'b1
    } t_cmd;

    typedef struct packed {
        logic              done;
        logic [5:0]        shift;
        logic [NORM_W-1:0] value;
    } t_norm_res;

endpackage

### rtl/romu_mul64.sv
module romu_mul64 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_p
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LL,
        PH_LH,
        PH_HL,
        PH_SUM
    } t_phase;

    t_phase      r_phase;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [63:0] r_p;
    logic        r_done;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] n_prod;

    // one 32x32 multiplier, three partial products give the low 64 bits
    always_comb begin
        unique case (r_phase)
            PH_LH: begin
                op_a = r_a[31:0];
                op_b = r_b[63:32];
            end
            PH_HL: begin
                op_a = r_a[63:32];
                op_b = r_b[31:0];
            end
            default: begin
                op_a = r_a[31:0];
                op_b = r_b[31:0];
            end
        endcase
        n_prod = {32'b0, op_a} * {32'b0, op_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_a;
                        r_b     <= i_b;
                        r_phase <= PH_LL;
                    end
                end
                PH_LL: begin
                    r_prod  <= n_prod;
                    r_phase <= PH_LH;
                end
                PH_LH: begin
                    r_acc   <= r_prod;
                    r_prod  <= n_prod;
                    r_phase <= PH_HL;
                end
                PH_HL: begin
                    r_acc[63:32] <= r_acc[63:32] + r_prod[31:0];
                    r_prod       <= n_prod;
                    r_phase      <= PH_SUM;
                end
                PH_SUM: begin
                    r_p     <= {r_acc[63:32] + r_prod[31:0], r_acc[31:0]};
                    r_done  <= 1'b1;
                    r_phase <= PH_IDLE;
                end
                default: r_phase <= PH_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

### rtl/romu_norm.sv
module romu_norm (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [romu_pkg::NORM_W-1:0]    i_value,
    output romu_pkg::t_norm_res            o_res
);

    logic [romu_pkg::NORM_W-1:0] r_v;
    logic [5:0]                  r_shift;
    logic [2:0]                  r_step;
    logic                        r_busy;
    logic                        r_done;
    logic [5:0]                  amt;
    logic [romu_pkg::NORM_W-1:0] mask;
    logic                        top_zero;

    // binary search: try shifts of 32, 16, 8, 4, 2, 1 in turn
    always_comb begin
        amt      = 6'd32 >> r_step;
        mask     = ~({romu_pkg::NORM_W{1'b1}} >> amt);
        top_zero = ((r_v & mask) == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                if (top_zero) begin
                    r_v     <= r_v << amt;
                    r_shift <= r_shift + amt;
                end
                if (r_step == 3'(romu_pkg::NORM_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 3'd1;
            end else if (i_start) begin
                r_v     <= i_value;
                r_shift <= '0;
                r_step  <= '0;
                r_busy  <= 1'b1;
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.shift = r_shift;
    assign o_res.value = r_v;

endmodule

### rtl/romu_quad_random_generator.sv
// RomuQuad random source with four 64-bit state words, all zero after reset.
// A reseed word (cmd 1) runs sixteen splitmix mixes from the seed register and
// loads every fourth result into the state; it gives no output word and keeps
// the input busy until the last mix is done. Each mix is one add, then two
// 64-bit products on the one shared 32x32 multiplier, each a start state and
// a wait for the product. A draw word (cmd 0) steps the state and returns
// the old second word, raw or as an exact float pattern: a raw word waits on
// the 64-bit product and is then loaded into the output, and each float lane
// adds a setup state and the six-step leading-one search.
// Only one word is worked on at a time; a new one is taken while the last
// result still waits on the output, and the next result waits until it leaves.
module romu_quad_random_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_seed_we,
    input  logic [63:0] i_seed_value,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] cmd, [3:1] out_format, [7:4] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [63:0] random_value
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MIX_ADD,
        S_MIX_START1,
        S_MIX_M1,
        S_MIX_START2,
        S_MIX_M2,
        S_DRAW_MUL,
        S_FMT,
        S_NORM,
        S_EMIT
    } t_state;

    t_state               r_state;
    logic [63:0]          r_seed;
    logic [63:0]          r_words [4];
    logic [63:0]          r_t;
    logic [3:0]           r_mix;
    romu_pkg::t_fmt       r_fmt;
    logic [63:0]          r_xout;
    logic                 r_lane;
    logic                 r_neg;
    logic                 r_zero;
    logic [63:0]          r_res;
    logic                 r_out_valid;
    logic [63:0]          r_out_data;

    logic                 in_fire;
    romu_pkg::t_cmd       in_cmd;
    logic                 mul_start;
    logic [63:0]          mul_a;
    logic [63:0]          mul_b;
    logic                 mul_done;
    logic [63:0]          mul_p;
    logic [63:0]          mix_mid;
    logic [63:0]          mix_end;

    logic                 f_raw;
    logic                 f_signed;
    logic                 f_f64;
    logic                 f_two;
    logic [10:0]          exp_base;
    logic [22:0]          m23;
    logic [23:0]          mag24;
    logic [51:0]          m52;
    logic [romu_pkg::NORM_W-1:0] mag53;
    logic [romu_pkg::NORM_W-1:0] norm_in;
    logic                 n_neg;
    romu_pkg::t_norm_res  norm_res;
    logic [10:0]          exp11;
    logic [63:0]          bits64;
    logic [31:0]          lane32;

    function automatic logic [63:0] n_yw(input logic [63:0] y, input logic [63:0] w);
        logic [63:0] s;
        s = y + w;
        return {s[63-romu_pkg::ROT_YW:0], s[63:64-romu_pkg::ROT_YW]};
    endfunction

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign in_cmd  = romu_pkg::t_cmd'(s_axis_tdata[0]);

    // operands for the shared multiplier
    always_comb begin
        unique case (r_state)
            S_IDLE: begin
                mul_a = r_words[3];
                mul_b = romu_pkg::ROMU_MUL;
            end
            S_MIX_START1: begin
                mul_a = r_t ^ (r_t >> romu_pkg::MIX_SHIFT0);
                mul_b = romu_pkg::MIX_MUL1;
            end
            default: begin
                mul_a = r_t;
                mul_b = romu_pkg::MIX_MUL2;
            end
        endcase
        mul_start = (in_fire && in_cmd == romu_pkg::CMD_DRAW)
                  || r_state == S_MIX_START1 || r_state == S_MIX_START2;
        mix_mid   = mul_p ^ (mul_p >> romu_pkg::MIX_SHIFT1);
        mix_end   = mul_p ^ (mul_p >> romu_pkg::MIX_SHIFT2);
    end

    romu_mul64 u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    // format decode and magnitude of the current lane
    always_comb begin
        f_raw    = 1'b0;
        f_signed = 1'b0;
        f_f64    = 1'b0;
        f_two    = 1'b0;
        unique case (r_fmt)
            romu_pkg::FMT_F32_S: f_signed = 1'b1;
            romu_pkg::FMT_F64_S: begin
                f_signed = 1'b1;
                f_f64    = 1'b1;
            end
            romu_pkg::FMT_F32_U: f_signed = 1'b0;
            romu_pkg::FMT_F64_U: f_f64 = 1'b1;
            romu_pkg::FMT_F32X2_S: begin
                f_signed = 1'b1;
                f_two    = 1'b1;
            end
            romu_pkg::FMT_F32X2_U: f_two = 1'b1;
            default: f_raw = 1'b1;
        endcase

        if (f_f64) begin
            exp_base = f_signed ? romu_pkg::EXP_F64_S : romu_pkg::EXP_F64_U;
        end else begin
            exp_base = f_signed ? romu_pkg::EXP_F32_S : romu_pkg::EXP_F32_U;
        end

        m23 = r_lane ? r_xout[54:32] : r_xout[22:0];
        if (f_signed && !m23[22]) begin
            mag24 = romu_pkg::F32_HALF - {1'b0, m23};
        end else if (f_signed) begin
            mag24 = {2'b0, m23[21:0]};
        end else begin
            mag24 = {1'b0, m23};
        end

        m52 = r_xout[51:0];
        if (f_signed && !m52[51]) begin
            mag53 = romu_pkg::F64_HALF - {1'b0, m52};
        end else if (f_signed) begin
            mag53 = {2'b0, m52[50:0]};
        end else begin
            mag53 = {1'b0, m52};
        end

        norm_in = f_f64 ? mag53 : {mag24, 29'b0};
        n_neg   = f_signed && (f_f64 ? !m52[51] : !m23[22]);

        exp11  = exp_base - {5'b0, norm_res.shift};
        bits64 = r_zero ? '0 : {r_neg, exp11, norm_res.value[51:0]};
        lane32 = r_zero ? '0 : {r_neg, exp11[7:0], norm_res.value[51:29]};
    end

    romu_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_FMT),
        .i_value (norm_in),
        .o_res   (norm_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_seed_we) begin
            r_seed <= i_seed_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mix       <= '0;
            r_lane      <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_words[i] <= '0;
            end
        end else begin
            // the emit state keeps the output word valid on its own
            if (r_out_valid && m_axis_tready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire && in_cmd == romu_pkg::CMD_RESEED) begin
                        r_t     <= r_seed;
                        r_mix   <= '0;
                        r_state <= S_MIX_ADD;
                    end else if (in_fire) begin
                        r_fmt      <= romu_pkg::t_fmt'(s_axis_tdata[3:1]);
                        r_xout     <= r_words[1];
                        r_lane     <= 1'b0;
                        r_words[1] <= r_words[3] + {r_words[0][63-romu_pkg::ROT_W:0],
                                      r_words[0][63:64-romu_pkg::ROT_W]};
                        r_words[2] <= r_words[2] - r_words[1];
                        r_words[3] <= {n_yw(r_words[2], r_words[0])};
                        r_state    <= S_DRAW_MUL;
                    end
                end
                S_MIX_ADD: begin
                    r_t     <= r_t + romu_pkg::GOLDEN_STEP;
                    r_state <= S_MIX_START1;
                end
                S_MIX_START1: r_state <= S_MIX_M1;
                S_MIX_M1: begin
                    if (mul_done) begin
                        r_t     <= mix_mid;
                        r_state <= S_MIX_START2;
                    end
                end
                S_MIX_START2: r_state <= S_MIX_M2;
                S_MIX_M2: begin
                    if (mul_done) begin
                        r_t <= mix_end;
                        // every fourth mix result lands in the next state word
                        if (r_mix[1:0] == 2'd3) begin
                            r_words[r_mix[3:2]] <= mix_end;
                        end
                        r_mix   <= r_mix + 4'd1;
                        r_state <= (r_mix == 4'd15) ? S_IDLE : S_MIX_ADD;
                    end
                end
                S_DRAW_MUL: begin
                    if (mul_done) begin
                        r_words[0] <= mul_p;
                        r_res      <= r_xout;
                        r_state    <= f_raw ? S_EMIT : S_FMT;
                    end
                end
                S_FMT: begin
                    r_neg   <= n_neg;
                    r_zero  <= (norm_in == '0);
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    if (norm_res.done) begin
                        if (f_f64) begin
                            r_res   <= bits64;
                            r_state <= S_EMIT;
                        end else if (!r_lane) begin
                            r_res   <= {32'b0, lane32};
                            r_lane  <= 1'b1;
                            r_state <= f_two ? S_FMT : S_EMIT;
                        end else begin
                            r_res[63:32] <= lane32;
                            r_state      <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_data  <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_mul_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_MIX_M1 || r_state == S_MIX_M2
                      || r_state == S_DRAW_MUL))
        else $error("multiplier result arrived outside a wait state");

    a_norm_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        norm_res.done |-> r_state == S_NORM)
        else $error("normalizer result arrived outside its wait state");

    a_reseed_starts_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && in_cmd == romu_pkg::CMD_RESEED) |=> r_state == S_MIX_ADD)
        else $error("reseed word did not start the mix chain");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_EMIT)
        else $error("output word loaded outside the emit state");

endmodule
